// ===== rtl/swa_pkg.sv =====
`default_nettype none

package swa_pkg;

  localparam int WINDOW_SLOTS = 32;
  localparam int SLOT_W       = $clog2(WINDOW_SLOTS);
  localparam int CNT_W        = $clog2(WINDOW_SLOTS + 1);
  localparam int SEQ_W        = 32;
  localparam int CMD_W        = 3;
  localparam int KIND_W       = 3;
  localparam int SLOT_OUT_W   = 5;
  localparam int RTO_W        = 31;
  localparam logic [RTO_W-1:0] RTO_RESET = RTO_W'(1000);

  // input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_SEND  = 3'd0,
    CMD_ACK   = 3'd1,
    CMD_DATA  = 3'd2,
    CMD_TICK  = 3'd3,
    CMD_HELLO = 3'd4
  } cmd_e;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_SENT        = 3'd0,
    KIND_REFUSED     = 3'd1,
    KIND_ACK_INORDER = 3'd2,
    KIND_ACK_DUP     = 3'd3,
    KIND_RESEND      = 3'd4,
    KIND_TICK_IDLE   = 3'd5,
    KIND_ACK_TAKEN   = 3'd6,
    KIND_ACK_IGNORED = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_END
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_item;   // input item accepted this cycle
    logic scan_step;   // current scan slot checked, advance
    logic scan_finish; // emit the final tick result
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;    // result register can take a new item
    logic is_tick;     // pending input item is a tick
    logic cnt_zero;    // nothing outstanding
    logic last_idx;    // scan is at the last outstanding slot
    logic due;         // current slot deadline has passed
    logic pend_valid;  // a resend is held back for its last flag
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/swa_if.sv =====
`default_nettype none

interface swa_item_if;
  logic                       valid;
  logic                       ready;
  logic [swa_pkg::CMD_W-1:0]  cmd;
  logic [swa_pkg::SEQ_W-1:0]  seq_in;
  logic [swa_pkg::SEQ_W-1:0]  now;

  modport source (output valid, output cmd, output seq_in, output now, input ready);
  modport sink   (input valid, input cmd, input seq_in, input now, output ready);
endinterface

interface swa_result_if;
  logic                            valid;
  logic                            ready;
  logic [swa_pkg::KIND_W-1:0]      kind;
  logic [swa_pkg::SEQ_W-1:0]       seq_out;
  logic [swa_pkg::SLOT_OUT_W-1:0]  slot;
  logic                            last;

  modport source (output valid, output kind, output seq_out, output slot, output last,
                  input ready);
  modport sink   (input valid, input kind, input seq_out, input slot, input last,
                  output ready);
endinterface

interface swa_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [swa_pkg::RTO_W-1:0]  retransmit_timeout;

  modport source (output valid, output retransmit_timeout, input ready);
  modport sink   (input valid, input retransmit_timeout, output ready);
endinterface

`default_nettype wire

// ===== rtl/sliding_window_arq_engine.sv =====
`default_nettype none

// sliding window arq bookkeeping with cumulative acks: sends get a sequence
// number, a window slot (sequence modulo 32) and a retransmit deadline of
// now + retransmit_timeout; sends are refused before the hello ack and while
// 32 numbers are outstanding. received data in order is acked and advances
// the expected number, anything else re-acks expected minus one. acks outside
// the outstanding range, including numbers never sent, are ignored. a tick
// walks the outstanding slots from the ack point and resends every slot whose
// deadline has passed (32-bit wrapping compare), restarting its deadline; if
// nothing is due it gives one tick idle result. a hello ack and unused
// commands give no result. send, ack and data items are accepted in the
// idle state and their result lands in the output register; a tick is
// accepted in the idle state, then each outstanding slot takes a read state
// and a check state, and a closing state gives the final result, as the
// deadline ram has a single read port whose read data is registered.
// one resend is held back until the next due slot or the end of the walk so
// its last flag is known, and stalls on the result side stretch the walk.
// the retransmit timeout register accepts a write every cycle and should only
// be written while the block is idle. deadline ram contents are not cleared
// at reset; only slots of sent numbers are ever read.

module sliding_window_arq_engine (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  swa_item_if.sink    item_i,
  swa_result_if.source result_o,
  swa_cfg_if.sink     cfg_i
);

  swa_pkg::ctrl_t ctrl;
  swa_pkg::stat_t stat;

  // config register is always writable
  assign cfg_i.ready = 1'b1;

  // sequencer: idle, slot read, slot check, closing result
  swa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // sequence counters, deadline ram, held resend and result register
  swa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (item_i.cmd),
    .seq_in_i    (item_i.seq_in),
    .now_i       (item_i.now),
    .cfg_valid_i (cfg_i.valid),
    .cfg_rto_i   (cfg_i.retransmit_timeout),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_kind_o  (result_o.kind),
    .out_seq_o   (result_o.seq_out),
    .out_slot_o  (result_o.slot),
    .out_last_o  (result_o.last),
    .ctrl_i      (ctrl),
    .stat_o      (stat)
  );

endmodule

`default_nettype wire

// ===== rtl/swa_ram.sv =====
`default_nettype none

module swa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/swa_ctrl.sv =====
`default_nettype none

module swa_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  input  wire swa_pkg::stat_t stat_i,
  output      swa_pkg::ctrl_t ctrl_o
);

  swa_pkg::state_e state_q, state_d;
  logic            scan_adv;

  // a due slot must wait while the held resend cannot be pushed out
  assign scan_adv = !(stat_i.due && stat_i.pend_valid && !stat_i.out_free);

  always_comb begin
    state_d = state_q;
    case (state_q)
      swa_pkg::ST_IDLE: begin
        if (in_valid_i && stat_i.out_free && stat_i.is_tick) begin
          state_d = stat_i.cnt_zero ? swa_pkg::ST_SCAN_END : swa_pkg::ST_SCAN_RD;
        end
      end
      swa_pkg::ST_SCAN_RD: begin
        state_d = swa_pkg::ST_SCAN_CHK;
      end
      swa_pkg::ST_SCAN_CHK: begin
        if (scan_adv) begin
          state_d = stat_i.last_idx ? swa_pkg::ST_SCAN_END : swa_pkg::ST_SCAN_RD;
        end
      end
      swa_pkg::ST_SCAN_END: begin
        if (stat_i.out_free) begin
          state_d = swa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    ctrl_o      = '0;
    case (state_q)
      swa_pkg::ST_IDLE: begin
        in_ready_o       = stat_i.out_free;
        ctrl_o.load_item = in_valid_i && stat_i.out_free;
      end
      swa_pkg::ST_SCAN_CHK: begin
        ctrl_o.scan_step = scan_adv;
      end
      swa_pkg::ST_SCAN_END: begin
        ctrl_o.scan_finish = stat_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/swa_dp.sv =====
`default_nettype none

module swa_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [swa_pkg::CMD_W-1:0]    cmd_i,
  input  wire logic [swa_pkg::SEQ_W-1:0]    seq_in_i,
  input  wire logic [swa_pkg::SEQ_W-1:0]    now_i,
  input  wire logic                         cfg_valid_i,
  input  wire logic [swa_pkg::RTO_W-1:0]    cfg_rto_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic [swa_pkg::KIND_W-1:0]   out_kind_o,
  output      logic [swa_pkg::SEQ_W-1:0]    out_seq_o,
  output      logic [swa_pkg::SLOT_OUT_W-1:0] out_slot_o,
  output      logic                         out_last_o,
  input  wire swa_pkg::ctrl_t               ctrl_i,
  output      swa_pkg::stat_t               stat_o
);

  localparam int SW = swa_pkg::SEQ_W;

  // sequence state
  logic [SW-1:0]               next_q, next_d;
  logic [SW-1:0]               ack_q, ack_d;
  logic [SW-1:0]               exp_q, exp_d;
  logic                        hello_wait_q, hello_wait_d;
  logic [swa_pkg::RTO_W-1:0]   rto_q;

  // scan state
  logic [swa_pkg::SLOT_W-1:0]  idx_q, idx_d;
  logic [SW-1:0]               now_q, now_d;
  logic                        pend_valid_q, pend_valid_d;
  logic [SW-1:0]               pend_seq_q, pend_seq_d;

  // result register
  logic                        out_valid_q, out_valid_d;
  swa_pkg::kind_e              out_kind_q, out_kind_d;
  logic [SW-1:0]               out_seq_q, out_seq_d;
  logic                        out_last_q, out_last_d;

  logic [SW-1:0]               outstanding;
  logic                        window_full;
  logic [swa_pkg::CNT_W-1:0]   cnt;
  logic                        out_free;
  logic [SW-1:0]               scan_seq;
  logic [swa_pkg::SLOT_W-1:0]  scan_addr;
  logic [SW-1:0]               dl_rdata;
  logic [SW-1:0]               dl_diff;
  logic                        due;
  logic                        ram_we;
  logic [swa_pkg::SLOT_W-1:0]  ram_waddr;
  logic [SW-1:0]               ram_wdata;
  logic [SW-1:0]               new_deadline;

  assign outstanding  = next_q - ack_q;
  assign window_full  = outstanding >= SW'(swa_pkg::WINDOW_SLOTS);
  assign cnt          = window_full ? swa_pkg::CNT_W'(swa_pkg::WINDOW_SLOTS)
                                    : outstanding[swa_pkg::CNT_W-1:0];
  assign out_free     = !out_valid_q || out_ready_i;
  assign scan_seq     = ack_q + SW'(idx_q);
  assign scan_addr    = scan_seq[swa_pkg::SLOT_W-1:0];
  assign dl_diff      = now_q - dl_rdata;
  assign due          = (dl_diff != '0) && !dl_diff[SW-1];

  always_comb begin
    next_d       = next_q;
    ack_d        = ack_q;
    exp_d        = exp_q;
    hello_wait_d = hello_wait_q;
    idx_d        = idx_q;
    now_d        = now_q;
    pend_valid_d = pend_valid_q;
    pend_seq_d   = pend_seq_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_kind_d   = out_kind_q;
    out_seq_d    = out_seq_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_waddr    = scan_addr;
    ram_wdata    = '0;
    new_deadline = now_i + SW'(rto_q);

    if (ctrl_i.load_item) begin
      case (cmd_i)
        swa_pkg::CMD_SEND: begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          out_seq_d   = next_q;
          if (hello_wait_q || window_full) begin
            out_kind_d = swa_pkg::KIND_REFUSED;
          end else begin
            out_kind_d = swa_pkg::KIND_SENT;
            next_d     = next_q + SW'(1);
            ram_we     = 1'b1;
            ram_waddr  = next_q[swa_pkg::SLOT_W-1:0];
            ram_wdata  = new_deadline;
          end
        end
        swa_pkg::CMD_ACK: begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          out_seq_d   = seq_in_i;
          // only numbers inside the outstanding range move the ack point
          if ((seq_in_i - ack_q) < outstanding) begin
            ack_d      = seq_in_i + SW'(1);
            out_kind_d = swa_pkg::KIND_ACK_TAKEN;
          end else begin
            out_kind_d = swa_pkg::KIND_ACK_IGNORED;
          end
        end
        swa_pkg::CMD_DATA: begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          if (seq_in_i == exp_q) begin
            exp_d      = seq_in_i + SW'(1);
            out_kind_d = swa_pkg::KIND_ACK_INORDER;
            out_seq_d  = seq_in_i;
          end else begin
            out_kind_d = swa_pkg::KIND_ACK_DUP;
            out_seq_d  = exp_q - SW'(1);
          end
        end
        swa_pkg::CMD_TICK: begin
          now_d        = now_i;
          idx_d        = '0;
          pend_valid_d = 1'b0;
        end
        swa_pkg::CMD_HELLO: begin
          hello_wait_d = 1'b0;
        end
        default: begin
          hello_wait_d = hello_wait_q;
        end
      endcase
    end

    if (ctrl_i.scan_step) begin
      idx_d = idx_q + swa_pkg::SLOT_W'(1);
      if (due) begin
        ram_we       = 1'b1;
        ram_waddr    = scan_addr;
        ram_wdata    = now_q + SW'(rto_q);
        pend_valid_d = 1'b1;
        pend_seq_d   = scan_seq;
        // the held resend is now known not to be the last one
        if (pend_valid_q) begin
          out_valid_d = 1'b1;
          out_kind_d  = swa_pkg::KIND_RESEND;
          out_seq_d   = pend_seq_q;
          out_last_d  = 1'b0;
        end
      end
    end

    if (ctrl_i.scan_finish) begin
      out_valid_d  = 1'b1;
      out_last_d   = 1'b1;
      pend_valid_d = 1'b0;
      if (pend_valid_q) begin
        out_kind_d = swa_pkg::KIND_RESEND;
        out_seq_d  = pend_seq_q;
      end else begin
        out_kind_d = swa_pkg::KIND_TICK_IDLE;
        out_seq_d  = ack_q;
      end
    end
  end

  swa_ram #(
    .WIDTH (SW),
    .DEPTH (swa_pkg::WINDOW_SLOTS)
  ) u_deadline_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_addr),
    .rdata_o (dl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q       <= '0;
      ack_q        <= '0;
      exp_q        <= '0;
      hello_wait_q <= 1'b1;
      rto_q        <= swa_pkg::RTO_RESET;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      next_q       <= next_d;
      ack_q        <= ack_d;
      exp_q        <= exp_d;
      hello_wait_q <= hello_wait_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i) begin
        rto_q <= cfg_rto_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    pend_seq_q <= pend_seq_d;
    out_kind_q <= out_kind_d;
    out_seq_q  <= out_seq_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_seq_o   = out_seq_q;
  assign out_slot_o  = swa_pkg::SLOT_OUT_W'(out_seq_q[swa_pkg::SLOT_W-1:0]);
  assign out_last_o  = out_last_q;

  assign stat_o.out_free   = out_free;
  assign stat_o.is_tick    = cmd_i == swa_pkg::CMD_TICK;
  assign stat_o.cnt_zero   = cnt == '0;
  assign stat_o.last_idx   = (swa_pkg::CNT_W'(idx_q) + swa_pkg::CNT_W'(1)) == cnt;
  assign stat_o.due        = due;
  assign stat_o.pend_valid = pend_valid_q;

endmodule

`default_nettype wire
